>>> design/btvf_pkg.sv
// Package for the blend/threshold/vote object filter.
// Frame geometry, field widths, window bit masks, payload and status types.
// No dependencies.
`default_nettype none

package btvf_pkg;

  localparam int IMG_WIDTH  = 512;
  localparam int IMG_HEIGHT = 512;

  localparam int COL_W   = $clog2(IMG_WIDTH);
  localparam int ROW_W   = $clog2(IMG_HEIGHT + 2);
  localparam int SCORE_W = 16;
  localparam int CFG_W   = 16;
  localparam int Q_FRAC  = 15;
  localparam int ONE_Q15 = 32768;
  localparam int PROD_W  = SCORE_W + Q_FRAC + 2;

  localparam int LB_W     = 4;
  localparam int WIN_W    = 18;
  localparam int COL_BITS = 6;
  localparam int VOTE_MIN = 3;

  localparam logic [WIN_W-1:0] LEFT_SEL  = 18'h071C7;
  localparam logic [WIN_W-1:0] RIGHT_SEL = 18'h38E38;
  localparam logic [WIN_W-1:0] TOP_SEL   = 18'h09249;
  localparam logic [WIN_W-1:0] BOT_SEL   = 18'h24924;

  localparam logic [CFG_W-1:0] BLEND_WEIGHT_RST   = 16'd16384;
  localparam logic [CFG_W-1:0] MASK_THRESHOLD_RST = 16'd16384;

  typedef enum logic [0:0] {
    CFG_BLEND_WEIGHT   = 1'b0,
    CFG_MASK_THRESHOLD = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [SCORE_W-1:0] left_stereo;
    logic [SCORE_W-1:0] left_motion;
    logic [SCORE_W-1:0] right_stereo;
    logic [SCORE_W-1:0] right_motion;
    logic               use_stereo;
    logic               flush;
  } btvf_in_t;

  typedef struct packed {
    logic left_object;
    logic right_object;
    logic frame_end;
  } btvf_out_t;

  // window position flags of one item
  typedef struct packed {
    logic             res_valid;
    logic             x_zero;
    logic             cx_zero;
    logic             cy_top;
    logic             cy_bottom;
    logic             last;
    logic [COL_W-1:0] col;
  } pos_t;

endpackage

`default_nettype wire

>>> design/btvf_if.sv
// Stream interfaces of the object filter: input pixel pair and output result.
// Depends on btvf_pkg.
`default_nettype none

interface btvf_in_if;
  import btvf_pkg::*;
  logic     valid;
  logic     ready;
  btvf_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface btvf_out_if;
  import btvf_pkg::*;
  logic      valid;
  logic      ready;
  btvf_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> design/btvf_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module btvf_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 512
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> design/btvf_lane.sv
// One score lane: blend of stereo and motion, strict threshold compare.
// Two register stages (products, then sum and compare). Depends on btvf_pkg.
`default_nettype none

module btvf_lane (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic                          pix_i,
  input  wire logic                          blend_i,
  input  wire logic [btvf_pkg::SCORE_W-1:0]  stereo_i,
  input  wire logic [btvf_pkg::SCORE_W-1:0]  motion_i,
  input  wire logic [btvf_pkg::CFG_W-1:0]    weight_i,
  input  wire logic [btvf_pkg::CFG_W-1:0]    thresh_i,
  output logic                               mask_o
);
  import btvf_pkg::*;

  logic        [2*SCORE_W-1:0]         prod_st_d, prod_st_q;
  logic signed [PROD_W-1:0]            prod_mo_d, prod_mo_q;
  logic signed [CFG_W+1:0]             comp_w;
  logic signed [CFG_W+SCORE_W+2:0]     prod_full;
  logic signed [PROD_W:0]              lhs, rhs;
  logic                                pix_q, mask_q;

  always_comb begin
    comp_w    = $signed((CFG_W+2)'(ONE_Q15)) - $signed({2'b00, weight_i});
    prod_full = comp_w * $signed({1'b0, motion_i});
    prod_st_d = blend_i ? weight_i * stereo_i : '0;
    prod_mo_d = blend_i ? $signed(prod_full[PROD_W-1:0])
                        : $signed({2'b00, motion_i, {Q_FRAC{1'b0}}});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_st_q <= prod_st_d;
      prod_mo_q <= prod_mo_d;
      pix_q     <= pix_i;
    end
  end

  assign lhs = $signed({2'b00, prod_st_q}) + $signed({prod_mo_q[PROD_W-1], prod_mo_q});
  assign rhs = $signed({3'b000, thresh_i, {Q_FRAC{1'b0}}});

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mask_q <= pix_q && (lhs > rhs);
    end
  end

  assign mask_o = mask_q;

endmodule

`default_nettype wire

>>> design/btvf_window.sv
// Merge stage: line buffer RAM, 3x3 window of both sides and the vote count.
// Depends on btvf_pkg and btvf_ram.
`default_nettype none

module btvf_window (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       adv_i,
  input  wire logic [btvf_pkg::COL_W-1:0] rd_addr_i,
  input  wire logic                       s2_valid_i,
  input  wire btvf_pkg::pos_t             pos_i,
  input  wire logic                       mask_l_i,
  input  wire logic                       mask_r_i,
  output logic                            res_valid_o,
  output btvf_pkg::btvf_out_t             res_o
);
  import btvf_pkg::*;

  logic             we;
  logic [LB_W-1:0]  wdata, rdata, lb_eff;
  logic [LB_W-1:0]  lb_s1_q, lb_s2_q;
  logic             byp_q;
  logic [LB_W-1:0]  byp_data_q;
  logic [WIN_W-1:0] win_q, shifted, win, keep;
  logic [COL_BITS-1:0] newcol;

  function automatic logic [4:0] popcnt(input logic [WIN_W-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 0; i < WIN_W; i++) begin
      n = n + 5'(v[i]);
    end
    return n;
  endfunction

  assign we    = adv_i && s2_valid_i;
  assign wdata = {mask_r_i, lb_s2_q[3], mask_l_i, lb_s2_q[1]};

  btvf_ram #(
    .WIDTH (LB_W),
    .DEPTH (IMG_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (pos_i.col),
    .wdata_i (wdata),
    .raddr_i (rd_addr_i),
    .rdata_o (rdata)
  );

  // read-during-write forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else begin
      byp_q <= we && (pos_i.col == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wdata;
  end

  assign lb_eff = byp_q ? byp_data_q : rdata;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      lb_s1_q <= lb_eff;
      lb_s2_q <= lb_s1_q;
    end
  end

  assign newcol  = {mask_r_i, lb_s2_q[3], lb_s2_q[2], mask_l_i, lb_s2_q[1], lb_s2_q[0]};
  assign shifted = {newcol, win_q[WIN_W-1:COL_BITS]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (we) begin
      win_q <= shifted;
    end
  end

  always_comb begin
    keep = '1;
    if (pos_i.cx_zero) begin
      keep[COL_BITS-1:0] = '0;
    end
    if (pos_i.cy_top) begin
      keep = keep & ~TOP_SEL;
    end
    if (pos_i.cy_bottom) begin
      keep = keep & ~BOT_SEL;
    end
    win = pos_i.x_zero ? {{COL_BITS{1'b0}}, win_q[WIN_W-1:COL_BITS]} : shifted;
    win = win & keep;
    res_o.left_object  = popcnt(win & LEFT_SEL) > 5'(VOTE_MIN);
    res_o.right_object = popcnt(win & RIGHT_SEL) > 5'(VOTE_MIN);
    res_o.frame_end    = pos_i.last;
  end

  assign res_valid_o = s2_valid_i && pos_i.res_valid;

endmodule

`default_nettype wire

>>> design/blend_threshold_vote_filter.sv
// Blend/threshold/vote object filter, top level. Accepts one transaction per clock
// while no output result is held; the item that completes a window passes both lane
// stages before the output register loads, so results lag input by IMG_WIDTH+1 items.
// A result that is not taken holds the whole pipeline and the input.
// Line buffer is a 512x4 RAM read one column ahead; it needs no clearing pass.
// Reset clears frame counters, pipeline valids, window and sets both registers to 16384.
`default_nettype none

module blend_threshold_vote_filter (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  btvf_in_if.sink                         in_i,
  btvf_out_if.source                      out_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [0:0]                 cfg_idx_i,
  input  wire logic [btvf_pkg::CFG_W-1:0] cfg_data_i
);
  import btvf_pkg::*;

  logic [CFG_W-1:0] weight_q, thresh_q;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             advance, in_fire;
  logic             s1_valid_q, s2_valid_q;
  pos_t             pos_d, s1_pos_q, s2_pos_q;
  logic             pix, mask_l, mask_r;
  logic             res_valid;
  btvf_out_t        res;
  logic             out_valid_q;
  btvf_out_t        out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weight_q <= BLEND_WEIGHT_RST;
      thresh_q <= MASK_THRESHOLD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_BLEND_WEIGHT:   weight_q <= cfg_data_i;
        CFG_MASK_THRESHOLD: thresh_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance     = !out_valid_q || out_o.ready;
  assign in_i.ready  = advance;
  assign in_fire     = in_i.valid && advance;

  always_comb begin
    pos_d.x_zero    = (col_q == '0);
    pos_d.cx_zero   = !pos_d.x_zero && (col_q == COL_W'(1));
    pos_d.res_valid = pos_d.x_zero ? (row_q >= ROW_W'(2)) : (row_q >= ROW_W'(1));
    pos_d.cy_top    = pos_d.x_zero ? (row_q == ROW_W'(2)) : (row_q == ROW_W'(1));
    pos_d.cy_bottom = pos_d.x_zero ? (row_q == ROW_W'(IMG_HEIGHT + 1))
                                   : (row_q == ROW_W'(IMG_HEIGHT));
    pos_d.last      = pos_d.x_zero && (row_q == ROW_W'(IMG_HEIGHT + 1));
    pos_d.col       = col_q;
    pix             = (row_q < ROW_W'(IMG_HEIGHT)) && !in_i.data.flush;

    col_d = col_q;
    row_d = row_q;
    if (in_fire) begin
      if (pos_d.x_zero && (row_q >= ROW_W'(IMG_HEIGHT + 1))) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == COL_W'(IMG_WIDTH - 1)) begin
        col_d = '0;
        row_d = row_q + ROW_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (advance) begin
        s1_valid_q  <= in_fire;
        s2_valid_q  <= s1_valid_q;
        out_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      s1_pos_q   <= pos_d;
      s2_pos_q   <= s1_pos_q;
      out_data_q <= res;
    end
  end

  btvf_lane u_lane_left (
    .clk_i    (clk_i),
    .en_i     (advance),
    .pix_i    (pix),
    .blend_i  (in_i.data.use_stereo),
    .stereo_i (in_i.data.left_stereo),
    .motion_i (in_i.data.left_motion),
    .weight_i (weight_q),
    .thresh_i (thresh_q),
    .mask_o   (mask_l)
  );

  btvf_lane u_lane_right (
    .clk_i    (clk_i),
    .en_i     (advance),
    .pix_i    (pix),
    .blend_i  (in_i.data.use_stereo),
    .stereo_i (in_i.data.right_stereo),
    .motion_i (in_i.data.right_motion),
    .weight_i (weight_q),
    .thresh_i (thresh_q),
    .mask_o   (mask_r)
  );

  btvf_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (advance),
    .rd_addr_i   (col_d),
    .s2_valid_i  (s2_valid_q),
    .pos_i       (s2_pos_q),
    .mask_l_i    (mask_l),
    .mask_r_i    (mask_r),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && (col_q == '0) && (row_q == ROW_W'(IMG_HEIGHT + 1))
    |=> (col_q == '0) && (row_q == '0))
    else $error("frame counters did not wrap after the last trailing transaction");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= ROW_W'(IMG_HEIGHT + 1)) && (col_q <= COL_W'(IMG_WIDTH - 1)))
    else $error("frame position out of range");

  a_trail_col: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q == ROW_W'(IMG_HEIGHT + 1)) |-> (col_q == '0))
    else $error("trailing row extends past its first column");

endmodule

`default_nettype wire
